// ----- hdl/shal_pkg.sv -----
package shal_pkg;

   // Fixed field widths of the item and result channels
   localparam int ACT_W     = 2;
   localparam int BIN_W     = 6;
   localparam int AMT_W     = 16;
   localparam int OCNT_W    = 16;
   localparam int ACNT_W    = 7;
   localparam int CFG_W     = 7;

   // Default sizing of the histogram
   localparam int DEF_NUM_BINS   = 64;
   localparam int DEF_COUNT_BITS = 16;

   // A dump stops after this many results
   localparam int MAX_OUT = 64;
   localparam int K_W     = 6;

   // bins_in_use after reset
   localparam logic [CFG_W-1:0] BINS_RESET = 7'd64;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_SUB   = 2'd1,
      ACT_DUMP  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RMW,
      ST_DUMP,
      ST_EMPTY,
      ST_CLEAR
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request transfer this cycle
      logic init_step;   // zero one counter of the reset sweep
      logic rmw;         // apply add / subtract and load the result
      logic dump_emit;   // load one dumped entry and advance the cursor
      logic empty_emit;  // load the empty-list result
      logic clr_step;    // zero one active counter and advance the cursor
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic init_done;
      logic head_null;
      logic next_null;
      logic dump_last;
      logic out_free;
   } sts_type;

   // Result payload
   typedef struct packed {
      logic [BIN_W-1:0]  out_bin;
      logic [OCNT_W-1:0] out_count;
      logic [ACNT_W-1:0] active_count;
      logic [ACNT_W-1:0] peak_active;
      logic              is_last;
      logic              list_empty;
      logic              error_flag;
   } rsp_pay_type;

endpackage

// ----- hdl/shal_if.sv -----
interface shal_req_if;
   import shal_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [BIN_W-1:0] bin_index;
   logic [AMT_W-1:0] amount;

   modport source(output valid, action, bin_index, amount, input ready);
   modport sink(input valid, action, bin_index, amount, output ready);
endinterface

interface shal_rsp_if;
   import shal_pkg::*;

   logic              valid;
   logic              ready;
   logic [BIN_W-1:0]  out_bin;
   logic [OCNT_W-1:0] out_count;
   logic [ACNT_W-1:0] active_count;
   logic [ACNT_W-1:0] peak_active;
   logic              is_last;
   logic              list_empty;
   logic              error_flag;

   modport source(output valid, out_bin, out_count, active_count, peak_active, is_last,
                  list_empty, error_flag, input ready);
   modport sink(input valid, out_bin, out_count, active_count, peak_active, is_last,
                list_empty, error_flag, output ready);
endinterface

// ----- hdl/shal_ctrl.sv -----
module shal_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [shal_pkg::ACT_W-1:0] req_action,
   output logic                    req_ready,
   input  shal_pkg::sts_type       sts,
   output shal_pkg::cmd_type       cmd
);
   import shal_pkg::*;

   state_type  state_ff, state_in;
   action_type act;

   assign act = action_type'(req_action);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (act)
                  ACT_ADD, ACT_SUB: state_in = ST_RMW;
                  ACT_DUMP:         state_in = sts.head_null ? ST_EMPTY : ST_DUMP;
                  ACT_CLEAR:        state_in = sts.head_null ? ST_IDLE : ST_CLEAR;
                  default:          state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_DUMP: begin
            if (sts.out_free && sts.dump_last) state_in = ST_IDLE;
         end
         ST_EMPTY: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (sts.next_null) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT:  cmd.init_step = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_RMW:   cmd.rmw        = sts.out_free;
         ST_DUMP:  cmd.dump_emit  = sts.out_free;
         ST_EMPTY: cmd.empty_emit = sts.out_free;
         ST_CLEAR: cmd.clr_step   = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/shal_dpath.sv -----
module shal_dpath #(
   parameter int NUM_BINS   = shal_pkg::DEF_NUM_BINS,
   parameter int COUNT_BITS = shal_pkg::DEF_COUNT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [shal_pkg::ACT_W-1:0] req_action,
   input  logic [shal_pkg::BIN_W-1:0] req_bin_index,
   input  logic [shal_pkg::AMT_W-1:0] req_amount,
   input  logic                       csr_wr_en,
   input  logic [shal_pkg::CFG_W-1:0] csr_wr_data,
   input  shal_pkg::cmd_type          cmd,
   output shal_pkg::sts_type          sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output shal_pkg::rsp_pay_type      rsp_pay
);
   import shal_pkg::*;

   localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam int TOT_W  = $clog2(NUM_BINS + 1);
   localparam int SUM_W  = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;
   localparam logic [LINK_W-1:0]     NIL  = LINK_W'(NUM_BINS);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   // Storage: counters and the two link arrays
   logic [COUNT_BITS-1:0] cnt_mem [NUM_BINS];
   logic [LINK_W-1:0]     nxt_mem [NUM_BINS];
   logic [LINK_W-1:0]     prv_mem [NUM_BINS];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [LINK_W-1:0]     nxt_rd_ff, prv_rd_ff;

   // Control registers
   logic [CFG_W-1:0]  bins_ff, bins_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [TOT_W-1:0]  peak_ff, peak_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;
   logic              rsp_vld_ff, rsp_vld_in;

   // Payload registers
   action_type        act_ff, act_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [AMT_W-1:0]  amt_ff, amt_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [K_W-1:0]    k_ff, k_in;
   rsp_pay_type       rsp_ff, rsp_in;

   // Memory ports
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  cnt_we, nxt_we, prv_we;
   logic [IDX_W-1:0]      cnt_wa, nxt_wa, prv_wa;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic [LINK_W-1:0]     nxt_wd, prv_wd;

   // Add / subtract arithmetic
   logic [SUM_W-1:0]      sum, c_ext, a_ext;
   logic [COUNT_BITS-1:0] sat, diff, new_cnt;
   logic                  is_add, bad, under, link_front, unlink;
   logic [IDX_W-1:0]      b_idx;
   logic [LINK_W-1:0]     b_link, p_link;
   logic                  dump_last;
   action_type            req_act;

   assign req_act = action_type'(req_action);

   // Bin index checks and counter update
   always_comb begin
      c_ext  = SUM_W'(cnt_rd_ff);
      a_ext  = SUM_W'(amt_ff);
      sum    = c_ext + a_ext;
      sat    = (sum > SUM_W'(CMAX)) ? CMAX : COUNT_BITS'(sum);
      under  = a_ext > c_ext;
      diff   = COUNT_BITS'(c_ext - a_ext);
      is_add = (act_ff == ACT_ADD);
      bad    = ({1'b0, bin_ff} >= bins_ff) || (32'(bin_ff) >= NUM_BINS);
      b_idx  = IDX_W'(bin_ff);
      b_link = {1'b0, b_idx};
      new_cnt    = is_add ? sat : diff;
      link_front = is_add && !bad && (cnt_rd_ff == '0) && (sat != '0);
      unlink     = !is_add && !bad && !under && (cnt_rd_ff != '0) && (diff == '0);
      // the head has no predecessor; its stored prev link is not always kept up to date
      p_link     = (b_link == head_ff) ? NIL : prv_rd_ff;
   end

   assign dump_last = (nxt_rd_ff == NIL) || (k_ff == K_W'(MAX_OUT - 1));

   // Status
   always_comb begin
      sts.init_done = (sweep_ff == IDX_W'(NUM_BINS - 1));
      sts.head_null = (head_ff == NIL);
      sts.next_null = (nxt_rd_ff == NIL);
      sts.dump_last = dump_last;
      sts.out_free  = !rsp_vld_ff || rsp_ready;
   end

   // Read address: the item's bin or the list head on a transfer, else the next link
   always_comb begin
      rd_en = cmd.accept || cmd.dump_emit || cmd.clr_step;
      if (cmd.accept) begin
         rd_addr = (req_act inside {ACT_ADD, ACT_SUB}) ? IDX_W'(req_bin_index)
                                                         : head_ff[IDX_W-1:0];
      end else begin
         rd_addr = nxt_rd_ff[IDX_W-1:0];
      end
   end

   // Write ports
   always_comb begin
      cnt_we = 1'b0;
      cnt_wa = b_idx;
      cnt_wd = new_cnt;
      nxt_we = 1'b0;
      nxt_wa = b_idx;
      nxt_wd = head_ff;
      prv_we = 1'b0;
      prv_wa = head_ff[IDX_W-1:0];
      prv_wd = b_link;
      if (cmd.init_step) begin
         cnt_we = 1'b1;
         cnt_wa = sweep_ff;
         cnt_wd = '0;
      end else if (cmd.clr_step) begin
         cnt_we = 1'b1;
         cnt_wa = cur_ff[IDX_W-1:0];
         cnt_wd = '0;
      end else if (cmd.rmw) begin
         cnt_we = !bad && (is_add || !under);
         if (link_front) begin
            nxt_we = 1'b1;
            prv_we = (head_ff != NIL);
         end else if (unlink) begin
            nxt_we = (p_link != NIL);
            nxt_wa = p_link[IDX_W-1:0];
            nxt_wd = nxt_rd_ff;
            prv_we = (nxt_rd_ff != NIL);
            prv_wa = nxt_rd_ff[IDX_W-1:0];
            prv_wd = p_link;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (rd_en) cnt_rd_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      if (rd_en) nxt_rd_ff <= nxt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) prv_mem[prv_wa] <= prv_wd;
      if (rd_en) prv_rd_ff <= prv_mem[rd_addr];
   end

   // Next values of registers and the result
   always_comb begin
      bins_in    = csr_wr_en ? csr_wr_data : bins_ff;
      head_in    = head_ff;
      total_in   = total_ff;
      peak_in    = peak_ff;
      sweep_in   = cmd.init_step ? sweep_ff + 1'b1 : sweep_ff;
      act_in     = act_ff;
      bin_in     = bin_ff;
      amt_in     = amt_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_ready ? 1'b0 : rsp_vld_ff;

      if (cmd.accept) begin
         act_in = req_act;
         bin_in = req_bin_index;
         amt_in = req_amount;
         cur_in = head_ff;
         k_in   = '0;
      end

      if (cmd.rmw) begin
         if (link_front) begin
            head_in  = b_link;
            total_in = total_ff + 1'b1;
            peak_in  = (total_in > peak_ff) ? total_in : peak_ff;
         end else if (unlink) begin
            if (p_link == NIL) head_in = nxt_rd_ff;
            total_in = (total_ff != '0) ? total_ff - 1'b1 : total_ff;
         end
         rsp_vld_in          = 1'b1;
         rsp_in.out_bin      = bin_ff;
         rsp_in.out_count    = bad ? '0 : OCNT_W'((is_add || !under) ? new_cnt : cnt_rd_ff);
         rsp_in.active_count = ACNT_W'(total_in);
         rsp_in.peak_active  = ACNT_W'(peak_in);
         rsp_in.is_last      = 1'b1;
         rsp_in.list_empty   = 1'b0;
         rsp_in.error_flag   = bad || (!is_add && under);
      end

      if (cmd.dump_emit) begin
         cur_in              = nxt_rd_ff;
         k_in                = k_ff + 1'b1;
         rsp_vld_in          = 1'b1;
         rsp_in.out_bin      = BIN_W'(cur_ff[IDX_W-1:0]);
         rsp_in.out_count    = OCNT_W'(cnt_rd_ff);
         rsp_in.active_count = ACNT_W'(total_ff);
         rsp_in.peak_active  = ACNT_W'(peak_ff);
         rsp_in.is_last      = dump_last;
         rsp_in.list_empty   = 1'b0;
         rsp_in.error_flag   = 1'b0;
      end

      if (cmd.empty_emit) begin
         rsp_vld_in          = 1'b1;
         rsp_in.out_bin      = '0;
         rsp_in.out_count    = '0;
         rsp_in.active_count = ACNT_W'(total_ff);
         rsp_in.peak_active  = ACNT_W'(peak_ff);
         rsp_in.is_last      = 1'b1;
         rsp_in.list_empty   = 1'b1;
         rsp_in.error_flag   = 1'b0;
      end

      // clear walks the active list; the list is empty once the tail is reached
      if (cmd.clr_step) begin
         cur_in = nxt_rd_ff;
         if (nxt_rd_ff == NIL) begin
            head_in  = NIL;
            total_in = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff    <= BINS_RESET;
         head_ff    <= NIL;
         total_ff   <= '0;
         peak_ff    <= '0;
         sweep_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         bins_ff    <= bins_in;
         head_ff    <= head_in;
         total_ff   <= total_in;
         peak_ff    <= peak_in;
         sweep_ff   <= sweep_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      bin_ff <= bin_in;
      amt_ff <= amt_in;
      cur_ff <= cur_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_pay   = rsp_ff;

endmodule

// ----- hdl/sparse_histogram_active_list_core.sv -----
// Sparse histogram with a linked list of its nonzero bins.
// req_if carries one item per transfer: add or subtract an amount to a bin, dump the
// active list, or clear every bin. rsp_if returns the results through an output
// register, so an item may be taken while an earlier result still waits there.
// csr_wr_en / csr_wr_data set bins_in_use; write it only while the block is idle.
// Add / subtract: one registered read of counter and links, then the update. Dump
// of N active bins: N results (N stops at 64), one result per cycle while the output
// register is free or being taken. Dump of an empty list: one result. Clear of N
// active bins: no result. The counter and link memories share a single read
// address; a clear, and a dump while not stalled, follow the list one link per cycle.
// After reset the block sweeps the counter memory to zero, one bin per cycle, and
// takes no request until the sweep is done; bins_in_use returns to 64.
// When rsp_if.ready is low the result holds in the output register and the block
// stops before loading the next one; nothing is dropped.
module sparse_histogram_active_list_core #(
   parameter int NUM_BINS   = shal_pkg::DEF_NUM_BINS,
   parameter int COUNT_BITS = shal_pkg::DEF_COUNT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   shal_req_if.sink                   req_if,
   shal_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [shal_pkg::CFG_W-1:0] csr_wr_data
);
   import shal_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   rsp_pay_type rsp_pay;

   shal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   shal_dpath #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_if.action),
      .req_bin_index (req_if.bin_index),
      .req_amount    (req_if.amount),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_pay       (rsp_pay)
   );

   // Result fields
   assign rsp_if.out_bin      = rsp_pay.out_bin;
   assign rsp_if.out_count    = rsp_pay.out_count;
   assign rsp_if.active_count = rsp_pay.active_count;
   assign rsp_if.peak_active  = rsp_pay.peak_active;
   assign rsp_if.is_last      = rsp_pay.is_last;
   assign rsp_if.list_empty   = rsp_pay.list_empty;
   assign rsp_if.error_flag   = rsp_pay.error_flag;

endmodule

// ----- tb/shal_histogram_monitor.sv -----
`timescale 1ns / 100ps

// Watches both channels and the CSR port, keeps its own copy of the histogram
// and the active list, and compares every result transfer with the oldest
// expected one.
module shal_histogram_monitor (
   input  logic                       clock,
   input  logic                       reset,
   shal_req_if                        req_mon,
   shal_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [shal_pkg::CFG_W-1:0] csr_wr_data,
   output int                         mismatches,
   output int                         pending,
   output int                         results_checked
);
   import shal_pkg::*;

   localparam int                NBINS   = DEF_NUM_BINS;
   localparam logic [ACNT_W-1:0] NO_LINK = ACNT_W'(NBINS);

   // Shadow histogram and list
   logic [OCNT_W-1:0] bin_count [NBINS];
   logic [ACNT_W-1:0] link_next [NBINS];
   logic [ACNT_W-1:0] link_prev [NBINS];
   logic [ACNT_W-1:0] list_head;
   logic [ACNT_W-1:0] live_bins;
   logic [ACNT_W-1:0] live_peak;
   logic [CFG_W-1:0]  bin_limit;

   rsp_pay_type awaited_rsp [$];
   int          fail_tally = 0;
   int          rsp_seen   = 0;

   initial begin
      mismatches      = 0;
      pending         = 0;
      results_checked = 0;
   end

   task automatic report(string what);
      fail_tally++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("result %0d %s: got %0h, want %0h", rsp_seen, name, got, want));
   endtask

   // Zero every bin and empty the list; the peak is left alone
   task automatic empty_histogram();
      for (int i = 0; i < NBINS; i++) begin
         bin_count[i] = '0;
         link_next[i] = NO_LINK;
         link_prev[i] = NO_LINK;
      end
      list_head = NO_LINK;
      live_bins = '0;
   endtask

   task automatic push_front(logic [BIN_W-1:0] b);
      link_prev[b] = NO_LINK;
      link_next[b] = list_head;
      if (list_head != NO_LINK)
         link_prev[list_head[BIN_W-1:0]] = {1'b0, b};
      list_head = {1'b0, b};
      live_bins++;
      if (live_bins > live_peak)
         live_peak = live_bins;
   endtask

   task automatic drop_bin(logic [BIN_W-1:0] b);
      logic [ACNT_W-1:0] p;
      logic [ACNT_W-1:0] n;
      p = link_prev[b];
      n = link_next[b];
      if (p != NO_LINK)
         link_next[p[BIN_W-1:0]] = n;
      else
         list_head = n;
      if (n != NO_LINK)
         link_prev[n[BIN_W-1:0]] = p;
      link_prev[b] = NO_LINK;
      link_next[b] = NO_LINK;
      if (live_bins != 0)
         live_bins--;
   endtask

   function automatic rsp_pay_type make_rsp(logic [BIN_W-1:0] b, logic [OCNT_W-1:0] cnt,
                                            logic last, logic empty, logic err);
      rsp_pay_type r;
      r.out_bin      = b;
      r.out_count    = cnt;
      r.active_count = live_bins;
      r.peak_active  = live_peak;
      r.is_last      = last;
      r.list_empty   = empty;
      r.error_flag   = err;
      return r;
   endfunction

   // Apply one item to the shadow state and queue the results it causes
   task automatic apply_item(action_type act, logic [BIN_W-1:0] b, logic [AMT_W-1:0] amt);
      logic [OCNT_W-1:0] c;
      logic [OCNT_W:0]   wide;
      logic [OCNT_W-1:0] s;
      logic [ACNT_W-1:0] cur;
      logic [ACNT_W-1:0] nx;
      int                k;
      case (act)
         ACT_ADD, ACT_SUB: begin
            if ({1'b0, b} >= bin_limit) begin
               awaited_rsp.push_back(make_rsp(b, '0, 1'b1, 1'b0, 1'b1));
            end else begin
               c = bin_count[b];
               if (act == ACT_ADD) begin
                  wide = {1'b0, c} + {1'b0, amt};
                  s    = wide[OCNT_W] ? '1 : wide[OCNT_W-1:0];
                  bin_count[b] = s;
                  if (c == 0 && s != 0)
                     push_front(b);
                  awaited_rsp.push_back(make_rsp(b, s, 1'b1, 1'b0, 1'b0));
               end else if (amt > c) begin
                  // underflow leaves the bin alone
                  awaited_rsp.push_back(make_rsp(b, c, 1'b1, 1'b0, 1'b1));
               end else begin
                  bin_count[b] = c - amt;
                  if (c != 0 && c == amt)
                     drop_bin(b);
                  awaited_rsp.push_back(make_rsp(b, bin_count[b], 1'b1, 1'b0, 1'b0));
               end
            end
         end
         ACT_DUMP: begin
            if (list_head == NO_LINK) begin
               awaited_rsp.push_back(make_rsp('0, '0, 1'b1, 1'b1, 1'b0));
            end else begin
               cur = list_head;
               k   = 0;
               while (cur != NO_LINK && k < MAX_OUT) begin
                  nx = link_next[cur[BIN_W-1:0]];
                  awaited_rsp.push_back(make_rsp(cur[BIN_W-1:0], bin_count[cur[BIN_W-1:0]],
                                                 nx == NO_LINK || k == MAX_OUT - 1,
                                                 1'b0, 1'b0));
                  k++;
                  cur = nx;
               end
            end
         end
         default: begin
            empty_histogram();
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_pay_type got;
      rsp_pay_type want;
      if (reset) begin
         empty_histogram();
         live_peak = '0;
         bin_limit = BINS_RESET;
         awaited_rsp.delete();
      end else begin
         // result transfer: compare with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen++;
            got.out_bin      = rsp_mon.out_bin;
            got.out_count    = rsp_mon.out_count;
            got.active_count = rsp_mon.active_count;
            got.peak_active  = rsp_mon.peak_active;
            got.is_last      = rsp_mon.is_last;
            got.list_empty   = rsp_mon.list_empty;
            got.error_flag   = rsp_mon.error_flag;
            if (awaited_rsp.size() == 0) begin
               report($sformatf("result %0d arrived with nothing expected (bin %0d)",
                                rsp_seen, got.out_bin));
            end else begin
               want = awaited_rsp.pop_front();
               check_field("out_bin",      got.out_bin,      want.out_bin);
               check_field("out_count",    got.out_count,    want.out_count);
               check_field("active_count", got.active_count, want.active_count);
               check_field("peak_active",  got.peak_active,  want.peak_active);
               check_field("is_last",      got.is_last,      want.is_last);
               check_field("list_empty",   got.list_empty,   want.list_empty);
               check_field("error_flag",   got.error_flag,   want.error_flag);
            end
         end
         if (csr_wr_en)
            bin_limit = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            apply_item(action_type'(req_mon.action), req_mon.bin_index, req_mon.amount);
      end
      mismatches      <= fail_tally;
      pending         <= awaited_rsp.size();
      results_checked <= rsp_seen;
   end

endmodule

// ----- tb/tb_sparse_histogram_active_list_core.sv -----
`timescale 1ns / 100ps

module tb_sparse_histogram_active_list_core;
   import shal_pkg::*;

   localparam int RUN_LIMIT = 8_000_000;
   localparam int HOLD_OFF  = 400;
   localparam int SETTLE    = 80;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   shal_req_if req_bus ();
   shal_rsp_if rsp_bus ();

   int          mismatches;
   int          pending;
   int          results_checked;
   int unsigned cycles         = 0;
   int          bin_limit      = DEF_NUM_BINS;
   int          issued [4]     = '{0, 0, 0, 0};
   int          settings_used  = 0;
   bit          hold_off_due   = 1'b0;
   bit          steady_sink    = 1'b0;
   bit          steady_source  = 1'b0;

   sparse_histogram_active_list_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   shal_histogram_monitor hist_mon (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      else if (r < 93)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic int source_gap();
      if (steady_source || $urandom_range(0, 99) < 60)
         return 0;
      return idle_len();
   endfunction

   // Result side: random stalls, plus the long hold-off when one is due
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else if (steady_sink || $urandom_range(0, 99) < 70) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   // One item, after a random gap; returns at the edge where it transfers
   task automatic offer(action_type act, int b, int amt);
      int gap;
      gap = source_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.bin_index <= b[BIN_W-1:0];
      req_bus.amount    <= amt[AMT_W-1:0];
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      issued[int'(act)]++;
   endtask

   // Drop valid and wait until every expected result is back and a clear has finished
   task automatic drain();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_bins(int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bin_limit   = value;
      settings_used++;
   endtask

   // Small counts dominate so that subtracts often reach zero or underflow
   task automatic random_item();
      int r;
      int b;
      int amt;
      if ($urandom_range(0, 99) < 15)
         b = $urandom_range(0, 63);
      else
         b = $urandom_range(0, bin_limit - 1);
      r = $urandom_range(0, 99);
      if (r < 15)
         amt = 0;
      else if (r < 65)
         amt = $urandom_range(1, 4);
      else if (r < 80)
         amt = $urandom_range(0, 65535);
      else if (r < 90)
         amt = 65535 - $urandom_range(0, 3);
      else
         amt = $urandom_range(5, 300);
      r = $urandom_range(0, 99);
      if (r < 46)
         offer(ACT_ADD, b, amt);
      else if (r < 82)
         offer(ACT_SUB, b, amt);
      else if (r < 97)
         offer(ACT_DUMP, b, amt);
      else
         offer(ACT_CLEAR, b, amt);
   endtask

   task automatic random_phase(int count);
      repeat (count) random_item();
   endtask

   // Add to every bin once in shuffled order, then dump the full list
   task automatic fill_all();
      int order [DEF_NUM_BINS];
      int j;
      int t;
      for (int i = 0; i < DEF_NUM_BINS; i++)
         order[i] = i;
      for (int i = DEF_NUM_BINS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < DEF_NUM_BINS; i++)
         offer(ACT_ADD, order[i], $urandom_range(1, 3));
      offer(ACT_DUMP, 0, 0);
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_ADD;
      req_bus.bin_index = '0;
      req_bus.amount    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the block clears its counters after reset
      repeat (DEF_NUM_BINS + 8) @(posedge clock);
      write_bins(64);

      // Directed: empty dump, zero add, saturation, underflow, unlink at head,
      // middle and tail, clear keeping the peak
      offer(ACT_DUMP, 0, 0);
      offer(ACT_ADD, 0, 0);
      offer(ACT_SUB, 5, 0);
      offer(ACT_ADD, 63, 65535);
      offer(ACT_ADD, 63, 1);
      offer(ACT_ADD, 0, 1);
      offer(ACT_ADD, 42, 16'h5A5A);
      offer(ACT_SUB, 0, 2);
      offer(ACT_ADD, 21, 16'hA5A5);
      offer(ACT_DUMP, 0, 0);
      offer(ACT_SUB, 63, 65535);
      offer(ACT_SUB, 21, 16'hA5A5);
      offer(ACT_ADD, 7, 3);
      offer(ACT_SUB, 42, 16'h5A5A);
      offer(ACT_DUMP, 0, 0);
      offer(ACT_ADD, 0, 65535);
      offer(ACT_CLEAR, 0, 0);
      offer(ACT_DUMP, 0, 0);
      offer(ACT_ADD, 7, 1);
      offer(ACT_SUB, 7, 1);
      offer(ACT_DUMP, 0, 0);

      // Full list: 64-entry dump, peak at its maximum
      fill_all();

      // Lowered limit with active bins above it; receiver holds off while
      // items keep coming so the block backs up
      drain();
      write_bins(37);
      hold_off_due  = 1'b1;
      steady_source = 1'b1;
      random_phase(30);
      steady_source = 1'b0;
      random_phase(60);

      // Smallest limit: only bin 0 is a good index, and most items go to bin 0
      drain();
      write_bins(1);
      random_phase(60);

      drain();
      write_bins(27);
      random_phase(100);

      // Full range, first stretch without any idling
      drain();
      write_bins(64);
      steady_sink   = 1'b1;
      steady_source = 1'b1;
      random_phase(40);
      steady_sink   = 1'b0;
      steady_source = 1'b0;
      random_phase(110);

      drain();
      $display("Covered %0d adds, %0d subtracts, %0d dumps, %0d clears over %0d bin limits",
               issued[ACT_ADD], issued[ACT_SUB], issued[ACT_DUMP], issued[ACT_CLEAR],
               settings_used);
      $display("%0d results compared, including a full-list dump and a %0d-cycle hold-off",
               results_checked, HOLD_OFF);
      if (mismatches == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
